// File: sv/stc_pkg.sv
// Shared types, sizes and helper functions for the strided transposed convolution block.
// No dependencies; stc_front, stc_back, the top level and the testbench import this package.
package stc_pkg;

    localparam int MAX_IN_DIM       = 32;
    localparam int MAX_FILTER_DIM   = 8;
    localparam int MAX_STRIDE       = 4;
    localparam int MAX_IN_CHANNELS  = 8;
    localparam int MAX_OUT_CHANNELS = 4;

    function automatic int f_bits(input int n);
        int b;
        b = 1;
        while ((1 << b) < n) b++;
        return b;
    endfunction

    localparam int ACT_DEPTH = MAX_IN_DIM * MAX_IN_DIM * MAX_IN_CHANNELS;
    localparam int WGT_DEPTH = MAX_FILTER_DIM * MAX_FILTER_DIM * MAX_OUT_CHANNELS
                             * MAX_IN_CHANNELS;
    localparam int RES_DIM   = (MAX_IN_DIM - 1) * MAX_STRIDE + MAX_FILTER_DIM;
    localparam int OUT_DEPTH = RES_DIM * RES_DIM * MAX_OUT_CHANNELS;

    localparam int ACT_AW = f_bits(ACT_DEPTH);
    localparam int WGT_AW = f_bits(WGT_DEPTH);
    localparam int OUT_AW = f_bits(OUT_DEPTH);

    localparam int OPC_W      = 2;
    localparam int IDX_W      = 17;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;

    localparam int DIM_W  = f_bits(MAX_IN_DIM + 1);
    localparam int FDIM_W = f_bits(MAX_FILTER_DIM + 1);
    localparam int STR_W  = f_bits(MAX_STRIDE + 1);
    localparam int ICH_W  = f_bits(MAX_IN_CHANNELS + 1);
    localparam int OCH_W  = f_bits(MAX_OUT_CHANNELS + 1);
    localparam int RD_W   = f_bits(RES_DIM + 1);
    localparam int I_W    = f_bits(MAX_IN_DIM);
    localparam int FI_W   = f_bits(MAX_FILTER_DIM);
    localparam int C_W    = f_bits(MAX_IN_CHANNELS);
    localparam int O_W    = f_bits(MAX_OUT_CHANNELS);

    localparam int HI_IN_DIM  = (32 < MAX_IN_DIM) ? 32 : MAX_IN_DIM;
    localparam int HI_FDIM    = (8 < MAX_FILTER_DIM) ? 8 : MAX_FILTER_DIM;
    localparam int HI_STRIDE  = (4 < MAX_STRIDE) ? 4 : MAX_STRIDE;
    localparam int HI_IN_CH   = (8 < MAX_IN_CHANNELS) ? 8 : MAX_IN_CHANNELS;
    localparam int HI_OUT_CH  = (4 < MAX_OUT_CHANNELS) ? 4 : MAX_OUT_CHANNELS;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [OPC_W-1:0] OP_LOAD_ACT = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_WGT = 2'd1;
    localparam logic [OPC_W-1:0] OP_RUN      = 2'd2;
    localparam logic [OPC_W-1:0] OP_READ     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_HEIGHT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WIDTH  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_H      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_W      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 4'd7;

    typedef enum logic [1:0] {K_LOAD_ACT, K_LOAD_WGT, K_RUN, K_READ} t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic [IDX_W-1:0]            idx;
        logic signed [SAMPLE_W-1:0]  value;
        logic                        in_range;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  w;
        logic [FDIM_W-1:0] fh;
        logic [FDIM_W-1:0] fw;
        logic [STR_W-1:0]  sh;
        logic [STR_W-1:0]  sw;
        logic [ICH_W-1:0]  ic;
        logic [OCH_W-1:0]  oc;
    } t_dims;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [IDX_W-1:0]        idx;
        logic                    run_done;
    } t_result;

    typedef struct packed {
        logic init_done;
    } t_status;

    function automatic logic [15:0] f_clamp(input logic [15:0] v, input int hi);
        logic [15:0] r;
        r = v;
        if (v == 16'd0) r = 16'd1;
        else if (v > 16'(hi)) r = 16'(hi);
        return r;
    endfunction

endpackage

// File: sv/stc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module stc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/stc_front.sv
// Front end: accepts input beats, classifies them, drops out-of-range loads and queues the rest.
// Depends on stc_pkg.
module stc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [stc_pkg::OPC_W-1:0]         i_opcode,
    input  logic [stc_pkg::IDX_W-1:0]         i_word_index,
    input  logic signed [stc_pkg::SAMPLE_W-1:0] i_sample_value,
    input  stc_pkg::t_status                  i_status,
    output logic                              o_head_valid,
    output stc_pkg::t_cmd                     o_head,
    input  logic                              i_pop
);
    import stc_pkg::*;

    t_cmd            r_queue [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    t_cmd            w_cmd;
    logic            w_keep;
    logic            w_push;

    always_comb begin
        w_cmd.idx      = i_word_index;
        w_cmd.value    = i_sample_value;
        w_cmd.kind     = K_RUN;
        w_cmd.in_range = 1'b1;
        case (i_opcode)
            OP_LOAD_ACT: begin
                w_cmd.kind     = K_LOAD_ACT;
                w_cmd.in_range = i_word_index < IDX_W'(ACT_DEPTH);
            end
            OP_LOAD_WGT: begin
                w_cmd.kind     = K_LOAD_WGT;
                w_cmd.in_range = i_word_index < IDX_W'(WGT_DEPTH);
            end
            OP_RUN: begin
                w_cmd.kind = K_RUN;
            end
            OP_READ: begin
                w_cmd.kind     = K_READ;
                w_cmd.in_range = i_word_index < IDX_W'(OUT_DEPTH);
            end
            default: begin
                w_cmd.kind = K_RUN;
            end
        endcase
        w_keep = w_cmd.in_range || (w_cmd.kind == K_RUN) || (w_cmd.kind == K_READ);
    end

    assign o_in_ready   = (r_count != (Q_AW + 1)'(Q_DEPTH)) && i_status.init_done;
    assign w_push       = i_in_valid && o_in_ready && w_keep;
    assign o_head_valid = r_count != '0;
    assign o_head       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// File: sv/stc_back.sv
// Back end: executes queued commands on the activation, weight and output stores.
// Depends on stc_pkg and stc_ram.
module stc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stc_pkg::t_dims   i_dims,
    input  logic             i_head_valid,
    input  stc_pkg::t_cmd    i_head,
    output logic             o_pop,
    output stc_pkg::t_status o_status,
    output logic             o_out_valid,
    output stc_pkg::t_result o_result,
    input  logic             i_out_ready
);
    import stc_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD_OUT, S_SETUP1, S_SETUP2, S_CLEAR,
        S_A1, S_A2, S_MUL, S_ACC, S_DONE
    } t_state;

    t_state                      r_state;
    logic                        r_init_done;
    logic [OUT_AW-1:0]           r_clr;
    logic                        r_out_valid;
    t_result                     r_out;
    logic [IDX_W-1:0]            r_rd_idx;
    logic                        r_rd_range;

    logic [ACT_AW-1:0]           r_hw;
    logic [RD_W-1:0]             r_hr;
    logic [RD_W-1:0]             r_wr;
    logic [WGT_AW-1:0]           r_fhfw;
    logic [WGT_AW-1:0]           r_fhfwoc;
    logic [OUT_AW-1:0]           r_hrwr;

    logic [O_W-1:0]              r_o;
    logic [I_W-1:0]              r_j;
    logic [I_W-1:0]              r_i;
    logic [C_W-1:0]              r_c;
    logic [FI_W-1:0]             r_jj;
    logic [FI_W-1:0]             r_ii;

    logic [ACT_AW-1:0]           r_t1;
    logic [ACT_AW-1:0]           r_t2;
    logic [WGT_AW-1:0]           r_w1;
    logic [WGT_AW-1:0]           r_w2;
    logic [WGT_AW-1:0]           r_w3;
    logic [RD_W-1:0]             r_row;
    logic [RD_W-1:0]             r_col;
    logic [OUT_AW-1:0]           r_o3;
    logic [OUT_AW-1:0]           r_oi;
    logic signed [2*SAMPLE_W-1:0] r_prod;

    logic [ACT_AW-1:0]           w_ai;
    logic [WGT_AW-1:0]           w_wi;
    logic [OUT_AW-1:0]           w_oi;
    logic                        w_free;
    logic                        w_out_load;
    logic                        w_run_end;
    logic                        w_last_ii, w_last_jj, w_last_c, w_last_i, w_last_j, w_last_o;

    logic                        w_act_we, w_wgt_we, w_out_we, w_out_re, w_tap_re;
    logic [OUT_AW-1:0]           w_out_waddr, w_out_raddr;
    logic [ACC_W-1:0]            w_out_wdata, w_sum;
    logic [SAMPLE_W-1:0]         w_act_rdata, w_wgt_rdata;
    logic [ACC_W-1:0]            w_out_rdata;

    assign w_free     = !r_out_valid || i_out_ready;
    assign w_out_load = ((r_state == S_RD_OUT) || (r_state == S_DONE)) && w_free;
    assign o_pop      = (r_state == S_IDLE) && i_head_valid;

    assign w_ai = ACT_AW'(r_i) + r_t1 + r_t2;
    assign w_wi = WGT_AW'(r_ii) + r_w1 + r_w2 + r_w3;
    assign w_oi = OUT_AW'(r_row) + OUT_AW'(r_hr) * OUT_AW'(r_col) + r_o3;

    assign w_last_ii = (FDIM_W'(r_ii) + 1'b1) == i_dims.fh;
    assign w_last_jj = (FDIM_W'(r_jj) + 1'b1) == i_dims.fw;
    assign w_last_c  = (ICH_W'(r_c) + 1'b1) == i_dims.ic;
    assign w_last_i  = (DIM_W'(r_i) + 1'b1) == i_dims.h;
    assign w_last_j  = (DIM_W'(r_j) + 1'b1) == i_dims.w;
    assign w_last_o  = (OCH_W'(r_o) + 1'b1) == i_dims.oc;
    assign w_run_end = w_last_ii && w_last_jj && w_last_c && w_last_i && w_last_j && w_last_o;

    assign w_sum = w_out_rdata + ACC_W'(r_prod);

    always_comb begin
        w_act_we    = o_pop && (i_head.kind == K_LOAD_ACT);
        w_wgt_we    = o_pop && (i_head.kind == K_LOAD_WGT);
        w_tap_re    = r_state == S_A2;
        w_out_re    = w_tap_re || (o_pop && (i_head.kind == K_READ) && i_head.in_range);
        w_out_raddr = w_tap_re ? w_oi : i_head.idx[OUT_AW-1:0];
        w_out_we    = (r_state == S_INIT) || (r_state == S_CLEAR) || (r_state == S_ACC);
        w_out_waddr = (r_state == S_ACC) ? r_oi : r_clr;
        w_out_wdata = (r_state == S_ACC) ? w_sum : '0;
    end

    stc_ram #(.WIDTH(SAMPLE_W), .DEPTH(ACT_DEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (i_head.idx[ACT_AW-1:0]),
        .i_wdata (i_head.value),
        .i_re    (w_tap_re),
        .i_raddr (w_ai),
        .o_rdata (w_act_rdata)
    );

    stc_ram #(.WIDTH(SAMPLE_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (i_head.idx[WGT_AW-1:0]),
        .i_wdata (i_head.value),
        .i_re    (w_tap_re),
        .i_raddr (w_wi),
        .o_rdata (w_wgt_rdata)
    );

    stc_ram #(.WIDTH(ACC_W), .DEPTH(OUT_DEPTH)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (w_out_we),
        .i_waddr (w_out_waddr),
        .i_wdata (w_out_wdata),
        .i_re    (w_out_re),
        .i_raddr (w_out_raddr),
        .o_rdata (w_out_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_done <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (r_clr == OUT_AW'(OUT_DEPTH - 1)) begin
                        r_clr       <= '0;
                        r_init_done <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        case (i_head.kind)
                            K_READ: begin
                                r_rd_idx   <= i_head.idx;
                                r_rd_range <= i_head.in_range;
                                r_state    <= S_RD_OUT;
                            end
                            K_RUN:   r_state <= S_SETUP1;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD_OUT: begin
                    if (w_free) begin
                        r_out.value    <= r_rd_range ? $signed(w_out_rdata) : '0;
                        r_out.idx      <= r_rd_idx;
                        r_out.run_done <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end
                S_SETUP1: begin
                    r_hw    <= ACT_AW'(i_dims.h) * ACT_AW'(i_dims.w);
                    r_hr    <= RD_W'(i_dims.h - 1'b1) * RD_W'(i_dims.sh) + RD_W'(i_dims.fh);
                    r_wr    <= RD_W'(i_dims.w - 1'b1) * RD_W'(i_dims.sw) + RD_W'(i_dims.fw);
                    r_fhfw  <= WGT_AW'(i_dims.fh) * WGT_AW'(i_dims.fw);
                    r_state <= S_SETUP2;
                end
                S_SETUP2: begin
                    r_hrwr   <= OUT_AW'(r_hr) * OUT_AW'(r_wr);
                    r_fhfwoc <= r_fhfw * WGT_AW'(i_dims.oc);
                    r_clr    <= '0;
                    r_state  <= S_CLEAR;
                end
                S_CLEAR: begin
                    if (r_clr == OUT_AW'(OUT_DEPTH - 1)) begin
                        r_clr   <= '0;
                        r_o     <= '0;
                        r_j     <= '0;
                        r_i     <= '0;
                        r_c     <= '0;
                        r_jj    <= '0;
                        r_ii    <= '0;
                        r_state <= S_A1;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_A1: begin
                    r_t1    <= ACT_AW'(i_dims.h) * ACT_AW'(r_j);
                    r_t2    <= r_hw * ACT_AW'(r_c);
                    r_w1    <= WGT_AW'(i_dims.fh) * WGT_AW'(r_jj);
                    r_w2    <= r_fhfw * WGT_AW'(r_o);
                    r_w3    <= r_fhfwoc * WGT_AW'(r_c);
                    r_row   <= RD_W'(r_i) * RD_W'(i_dims.sh) + RD_W'(r_ii);
                    r_col   <= RD_W'(r_j) * RD_W'(i_dims.sw) + RD_W'(r_jj);
                    r_o3    <= r_hrwr * OUT_AW'(r_o);
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_oi    <= w_oi;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= $signed(w_act_rdata) * $signed(w_wgt_rdata);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= w_run_end ? S_DONE : S_A1;
                    if (!w_last_ii) begin
                        r_ii <= r_ii + 1'b1;
                    end else begin
                        r_ii <= '0;
                        if (!w_last_jj) begin
                            r_jj <= r_jj + 1'b1;
                        end else begin
                            r_jj <= '0;
                            if (!w_last_c) begin
                                r_c <= r_c + 1'b1;
                            end else begin
                                r_c <= '0;
                                if (!w_last_i) begin
                                    r_i <= r_i + 1'b1;
                                end else begin
                                    r_i <= '0;
                                    if (!w_last_j) begin
                                        r_j <= r_j + 1'b1;
                                    end else begin
                                        r_j <= '0;
                                        if (!w_last_o) begin
                                            r_o <= r_o + 1'b1;
                                        end else begin
                                            r_o <= '0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (w_free) begin
                        r_out.value    <= '0;
                        r_out.idx      <= '0;
                        r_out.run_done <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status.init_done = r_init_done;
    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;
endmodule

// File: sv/strided_transposed_conv2d_top.sv
// Top level of the strided transposed convolution block: configuration registers,
// front end queue and back end engine. Depends on stc_pkg, stc_front and stc_back.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready    | i_opcode, i_word_index, i_sample_value
//  out      | o_out_valid / i_out_ready  | o_read_value, o_read_index, o_run_done
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Loads retire at one per cycle while the back end is in S_IDLE; a read fetches its
// output store word and waits in S_RD_OUT for the out channel. A run passes S_SETUP1,
// S_SETUP2 and S_CLEAR (all 69696 output words), then does a read-modify-write in S_A1,
// S_A2, S_MUL and S_ACC per tap (H*W*IC*FH*FW*OC taps). S_INIT clears the output store
// after reset with o_in_ready low. A four-entry queue holds beats while a result waits.
module strided_transposed_conv2d_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [stc_pkg::OPC_W-1:0]            i_opcode,
    input  logic [stc_pkg::IDX_W-1:0]            i_word_index,
    input  logic signed [stc_pkg::SAMPLE_W-1:0]  i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [stc_pkg::ACC_W-1:0]     o_read_value,
    output logic [stc_pkg::IDX_W-1:0]            o_read_index,
    output logic                                 o_run_done,
    input  logic                                 i_cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import stc_pkg::*;

    logic [5:0] r_in_height, r_in_width;
    logic [3:0] r_filter_height, r_filter_width;
    logic [2:0] r_stride_h, r_stride_w;
    logic [3:0] r_in_channels;
    logic [2:0] r_out_channels;

    t_dims   w_dims;
    t_status w_status;
    t_cmd    w_head;
    t_result w_result;
    logic    w_head_valid;
    logic    w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height     <= 6'd1;
            r_in_width      <= 6'd1;
            r_filter_height <= 4'd1;
            r_filter_width  <= 4'd1;
            r_stride_h      <= 3'd1;
            r_stride_w      <= 3'd1;
            r_in_channels   <= 4'd1;
            r_out_channels  <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IN_HEIGHT:     r_in_height     <= i_cfg_data[5:0];
                REG_IN_WIDTH:      r_in_width      <= i_cfg_data[5:0];
                REG_FILTER_HEIGHT: r_filter_height <= i_cfg_data[3:0];
                REG_FILTER_WIDTH:  r_filter_width  <= i_cfg_data[3:0];
                REG_STRIDE_H:      r_stride_h      <= i_cfg_data[2:0];
                REG_STRIDE_W:      r_stride_w      <= i_cfg_data[2:0];
                REG_IN_CHANNELS:   r_in_channels   <= i_cfg_data[3:0];
                REG_OUT_CHANNELS:  r_out_channels  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_dims.h  = DIM_W'(f_clamp(16'(r_in_height), HI_IN_DIM));
        w_dims.w  = DIM_W'(f_clamp(16'(r_in_width), HI_IN_DIM));
        w_dims.fh = FDIM_W'(f_clamp(16'(r_filter_height), HI_FDIM));
        w_dims.fw = FDIM_W'(f_clamp(16'(r_filter_width), HI_FDIM));
        w_dims.sh = STR_W'(f_clamp(16'(r_stride_h), HI_STRIDE));
        w_dims.sw = STR_W'(f_clamp(16'(r_stride_w), HI_STRIDE));
        w_dims.ic = ICH_W'(f_clamp(16'(r_in_channels), HI_IN_CH));
        w_dims.oc = OCH_W'(f_clamp(16'(r_out_channels), HI_OUT_CH));
    end

    stc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_sample_value (i_sample_value),
        .i_status       (w_status),
        .o_head_valid   (w_head_valid),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    stc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dims       (w_dims),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .o_result     (w_result),
        .i_out_ready  (i_out_ready)
    );

    assign o_read_value = w_result.value;
    assign o_read_index = w_result.idx;
    assign o_run_done   = w_result.run_done;

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("Command popped from an empty queue.");

    a_done_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_done) |-> (o_read_value == '0 && o_read_index == '0))
        else $error("Run completion beat carries a non-zero payload.");

    a_init_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.init_done |=> w_status.init_done)
        else $error("Initial clear flag dropped without reset.");
endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for strided_transposed_conv2d_top: loads stores, runs
// convolutions under several register settings and checks every output beat.
// Depends on stc_pkg and the strided_transposed_conv2d_top RTL.
`timescale 1ns / 1ps

module testbench;
    import stc_pkg::*;

    localparam int LIMIT = 4_000_000;
    localparam int REG_BITS [8] = '{6, 6, 4, 4, 3, 3, 4, 3};
    localparam int REG_TOP  [8] = '{HI_IN_DIM, HI_IN_DIM, HI_FDIM, HI_FDIM,
                                    HI_STRIDE, HI_STRIDE, HI_IN_CH, HI_OUT_CH};

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [OPC_W-1:0]            opcode;
    logic [IDX_W-1:0]            word_index;
    logic signed [SAMPLE_W-1:0]  sample_value;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [ACC_W-1:0]     read_value;
    logic [IDX_W-1:0]            read_index;
    logic                        run_done;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    logic [5:0]                  shadow_regs [8];
    logic signed [15:0]          act_words [ACT_DEPTH];
    logic signed [15:0]          wgt_words [WGT_DEPTH];
    logic [ACC_W-1:0]            acc_words [OUT_DEPTH];
    t_result                     awaited_outputs [$];
    int                          error_count;
    int                          item_count;
    int                          cycle_count;
    bit                          calm;

    strided_transposed_conv2d_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (opcode),
        .i_word_index   (word_index),
        .i_sample_value (sample_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_read_value   (read_value),
        .o_read_index   (read_index),
        .o_run_done     (run_done),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < LIMIT) @(posedge i_clk);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int eff_reg(input int k);
        int v;
        v = shadow_regs[k];
        if (v < 1) v = 1;
        if (v > REG_TOP[k]) v = REG_TOP[k];
        return v;
    endfunction

    task automatic scatter_accumulate();
        int h, w, fh, fw, sh, sw, ic, oc, hr, wr, ai, wi, oi;
        logic signed [31:0] p;
        h = eff_reg(0); w = eff_reg(1); fh = eff_reg(2); fw = eff_reg(3);
        sh = eff_reg(4); sw = eff_reg(5); ic = eff_reg(6); oc = eff_reg(7);
        hr = (h - 1) * sh + fh;
        wr = (w - 1) * sw + fw;
        foreach (acc_words[k]) acc_words[k] = '0;
        for (int o = 0; o < oc; o++)
            for (int j = 0; j < w; j++)
                for (int i = 0; i < h; i++)
                    for (int c = 0; c < ic; c++) begin
                        ai = i + h * j + h * w * c;
                        if (ai < ACT_DEPTH)
                            for (int jj = 0; jj < fw; jj++)
                                for (int ii = 0; ii < fh; ii++) begin
                                    wi = ii + fh * jj + fh * fw * o + fh * fw * oc * c;
                                    oi = (i * sh + ii) + hr * (j * sw + jj) + hr * wr * o;
                                    if (wi < WGT_DEPTH && oi < OUT_DEPTH) begin
                                        p = 32'(act_words[ai]) * 32'(wgt_words[wi]);
                                        acc_words[oi] = acc_words[oi] + 48'(p);
                                    end
                                end
                    end
    endtask

    task automatic predict_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic signed [SAMPLE_W-1:0] val);
        t_result r;
        case (op)
            OP_LOAD_ACT: begin
                if (idx < ACT_DEPTH) act_words[idx] = val;
            end
            OP_LOAD_WGT: begin
                if (idx < WGT_DEPTH) wgt_words[idx] = val;
            end
            OP_RUN: begin
                scatter_accumulate();
                r.value = '0; r.idx = '0; r.run_done = 1'b1;
                awaited_outputs.push_back(r);
            end
            default: begin
                r.value = (idx < OUT_DEPTH) ? acc_words[idx] : '0;
                r.idx = idx; r.run_done = 1'b0;
                awaited_outputs.push_back(r);
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] val);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        word_index   <= idx;
        sample_value <= val;
        do @(posedge i_clk); while (!in_ready);
        predict_item(op, idx, val);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic program_regs(input t_reg_write writes [$]);
        foreach (writes[k]) begin
            cfg_we    <= 1'b1;
            cfg_index <= writes[k].idx;
            cfg_data  <= writes[k].data;
            if (writes[k].idx < 8)
                shadow_regs[writes[k].idx] = writes[k].data & ((1 << REG_BITS[writes[k].idx]) - 1);
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_operands();
        int n_act, n_wgt;
        n_act = eff_reg(0) * eff_reg(1) * eff_reg(6);
        n_wgt = eff_reg(2) * eff_reg(3) * eff_reg(7) * eff_reg(6);
        for (int k = 0; k < n_act; k++) send_item(OP_LOAD_ACT, IDX_W'(k), 16'($urandom));
        for (int k = 0; k < n_wgt; k++) send_item(OP_LOAD_WGT, IDX_W'(k), 16'($urandom));
    endtask

    task automatic read_back(input int n_reads);
        int span;
        span = ((eff_reg(0) - 1) * eff_reg(4) + eff_reg(2))
             * ((eff_reg(1) - 1) * eff_reg(5) + eff_reg(3)) * eff_reg(7);
        for (int k = 0; k < n_reads; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item($urandom_range(0, 1) ? OP_LOAD_ACT : OP_LOAD_WGT,
                          IDX_W'($urandom), 16'($urandom));
            else if ($urandom_range(0, 3) == 0)
                send_item(OP_READ, IDX_W'($urandom), 16'($urandom));
            else
                send_item(OP_READ, IDX_W'($urandom_range(0, span - 1)), 16'($urandom));
        end
    endtask

    task automatic test_directed_defaults();
        send_item(OP_READ, 17'd5, 16'sd0);
        send_item(OP_LOAD_ACT, 17'd0, -16'sd32768);
        send_item(OP_LOAD_WGT, 17'd0, -16'sd32768);
        send_item(OP_LOAD_ACT, 17'(ACT_DEPTH), 16'sd1234);
        send_item(OP_LOAD_ACT, 17'h1FFFF, 16'sd4321);
        send_item(OP_LOAD_WGT, 17'(WGT_DEPTH), 16'sd777);
        send_item(OP_LOAD_WGT, 17'h1FFFF, -16'sd1);
        send_item(OP_RUN, 17'h1FFFF, 16'sd0);
        send_item(OP_READ, 17'd0, 16'sd0);
        send_item(OP_READ, 17'd1, 16'sd0);
        send_item(OP_READ, 17'(OUT_DEPTH - 1), 16'sd0);
        send_item(OP_READ, 17'(OUT_DEPTH), 16'sd0);
        send_item(OP_READ, 17'h1FFFF, 16'sd0);
        send_item(OP_LOAD_ACT, 17'd0, 16'sd32767);
        send_item(OP_RUN, 17'd0, 16'sd0);
        send_item(OP_READ, 17'd0, 16'sd0);
        drain_and_settle();
    endtask

    task automatic test_register_clamping();
        t_reg_write w [$];
        w.push_back('{REG_IN_HEIGHT, 6'd0});
        w.push_back('{REG_IN_WIDTH, 6'd63});
        w.push_back('{REG_FILTER_HEIGHT, 6'd15});
        w.push_back('{REG_FILTER_WIDTH, 6'd0});
        w.push_back('{REG_STRIDE_H, 6'd7});
        w.push_back('{REG_STRIDE_W, 6'd0});
        w.push_back('{REG_IN_CHANNELS, 6'd63});
        w.push_back('{REG_OUT_CHANNELS, 6'd63});
        for (int k = 8; k < 16; k++) w.push_back('{4'(k), 6'd0});
        program_regs(w);
        load_operands();
        send_item(OP_RUN, 17'd0, 16'sd0);
        read_back(100);
        drain_and_settle();
    endtask

    task automatic test_large_map();
        t_reg_write w [$];
        w.push_back('{REG_IN_HEIGHT, 6'd32});
        w.push_back('{REG_IN_WIDTH, 6'd16});
        w.push_back('{REG_FILTER_HEIGHT, 6'd8});
        w.push_back('{REG_FILTER_WIDTH, 6'd8});
        w.push_back('{REG_STRIDE_H, 6'd4});
        w.push_back('{REG_STRIDE_W, 6'd4});
        w.push_back('{REG_IN_CHANNELS, 6'd1});
        w.push_back('{REG_OUT_CHANNELS, 6'd1});
        program_regs(w);
        load_operands();
        send_item(OP_RUN, 17'd0, 16'sd0);
        read_back(100);
        drain_and_settle();
    endtask

    task automatic test_random_settings(input int n_phases);
        t_reg_write w [$];
        for (int ph = 0; ph < n_phases; ph++) begin
            w.delete();
            w.push_back('{REG_IN_HEIGHT, 6'($urandom_range(1, 8))});
            w.push_back('{REG_IN_WIDTH, 6'($urandom_range(1, 8))});
            w.push_back('{REG_FILTER_HEIGHT, 6'($urandom_range(1, 4))});
            w.push_back('{REG_FILTER_WIDTH, 6'($urandom_range(1, 4))});
            w.push_back('{REG_STRIDE_H, 6'($urandom_range(1, 4))});
            w.push_back('{REG_STRIDE_W, 6'($urandom_range(1, 4))});
            w.push_back('{REG_IN_CHANNELS, 6'($urandom_range(1, 4))});
            w.push_back('{REG_OUT_CHANNELS, 6'($urandom_range(1, 4))});
            program_regs(w);
            if (ph == n_phases - 1) calm = 1'b1;
            load_operands();
            send_item(OP_RUN, IDX_W'($urandom), 16'($urandom));
            read_back(80);
            drain_and_settle();
        end
    endtask

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_valid && out_ready) begin
            if (awaited_outputs.size() == 0) begin
                $display("%0t: unexpected beat value %0d index %0d done %0b",
                         $time, read_value, read_index, run_done);
                error_count++;
            end else begin
                exp_r = awaited_outputs.pop_front();
                if (read_value !== exp_r.value) begin
                    $display("%0t: read_value expected %0d got %0d", $time, exp_r.value, read_value);
                    error_count++;
                end
                if (read_index !== exp_r.idx) begin
                    $display("%0t: read_index expected %0d got %0d", $time, exp_r.idx, read_index);
                    error_count++;
                end
                if (run_done !== exp_r.run_done) begin
                    $display("%0t: run_done expected %0b got %0b", $time, exp_r.run_done, run_done);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cycle_count  = 0;
        error_count  = 0;
        item_count   = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_LOAD_ACT;
        word_index   = '0;
        sample_value = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_IN_HEIGHT;
        cfg_data     = '0;
        foreach (shadow_regs[k]) shadow_regs[k] = 6'd1;
        foreach (act_words[k]) act_words[k] = '0;
        foreach (wgt_words[k]) wgt_words[k] = '0;
        foreach (acc_words[k]) acc_words[k] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_defaults();
        test_register_clamping();
        test_large_map();
        test_random_settings(4);

        while (awaited_outputs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: strided_transposed_conv2d_top.f
sv/stc_pkg.sv
sv/stc_ram.sv
sv/stc_front.sv
sv/stc_back.sv
sv/strided_transposed_conv2d_top.sv
tb/sv/testbench.sv
